// File: rtl/ges_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian elimination solver package
// Shared command and status types and the codes used between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ges_pkg;

    // Fixed widths of the transaction fields.
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int SIZE_W  = 4;
    // Largest number of results one solve may emit.
    localparam int RES_LIMIT = 8;

    // Memory select codes for reads and writes.
    localparam logic [1:0] MEM_NONE = 2'd0;
    localparam logic [1:0] MEM_A    = 2'd1;
    localparam logic [1:0] MEM_B    = 2'd2;
    localparam logic [1:0] MEM_X    = 2'd3;

    // Write data source codes.
    localparam logic [1:0] SRC_DIV = 2'd0;
    localparam logic [1:0] SRC_SUB = 2'd1;
    localparam logic [1:0] SRC_ACC = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_en;
        logic [1:0] rd_mem;
        logic [1:0] wr_mem;
        logic [1:0] wr_src;
        logic       ld_p;
        logic       ld_f;
        logic       ld_t;
        logic       ld_acc;
        logic       acc_sub;
        logic       div_start;
        logic       out_ld;
        logic       out_sing;
        logic       out_final;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rd_zero;
        logic div_done;
    } t_sts;

endpackage

// File: rtl/ges_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed point divider
// Restoring divider, one quotient bit per cycle. Computes
// num * 2^FRAC_BITS / den truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module ges_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ges_pkg::DATA_W-1:0] i_num,
    input  logic signed [ges_pkg::DATA_W-1:0] i_den,
    output logic                              o_done,
    output logic signed [ges_pkg::DATA_W-1:0] o_quot
);

    localparam int NB = ges_pkg::DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam int DW = ges_pkg::DATA_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NB-1:0] r_dvd;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;

    logic [DW-1:0] w_num_mag;
    logic [DW-1:0] w_den_mag;
    logic [DW:0]   w_rem_sh;
    logic          w_ge;
    logic          w_ovf;
    logic [DW-1:0] w_low;

    // Operand magnitudes.
    assign w_num_mag = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign w_den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);

    // One restoring step.
    assign w_rem_sh = {r_rem[DW-1:0], r_dvd[NB-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out on the left while quotient bits enter on the right.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {w_num_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= w_den_mag;
            r_neg <= i_num[DW-1] ^ i_den[DW-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
            r_dvd <= {r_dvd[NB-2:0], w_ge};
        end
    end

    // Sign and saturation of the quotient magnitude.
    assign w_low = r_dvd[DW-1:0];
    always_comb begin
        if (r_neg) begin
            w_ovf  = (|r_dvd[NB-1:DW]) || (r_dvd[DW-1] && (|r_dvd[DW-2:0]));
            o_quot = w_ovf ? {1'b1, {(DW-1){1'b0}}} : DW'(-w_low);
        end else begin
            w_ovf  = |r_dvd[NB-1:DW-1];
            o_quot = w_ovf ? {1'b0, {(DW-1){1'b1}}} : w_low;
        end
    end

    assign o_done = r_done;

endmodule

// File: rtl/ges_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian elimination datapath
// Coefficient, right-hand side and solution memories, the multiply and
// subtract unit, the divider and the result register.
// ----------------------------------------------------------------------------
module ges_dp #(
    parameter int MAX_N     = 8,
    parameter int FRAC_BITS = 16,
    parameter int IW        = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ges_pkg::t_cmd                        i_cmd,
    input  logic [IW-1:0]                        i_row_addr,
    input  logic [IW-1:0]                        i_col_addr,
    output ges_pkg::t_sts                        o_sts,
    input  logic [ges_pkg::IDX_W-1:0]            i_row,
    input  logic [ges_pkg::IDX_W-1:0]            i_col,
    input  logic                                 i_is_rhs,
    input  logic signed [ges_pkg::DATA_W-1:0]    i_value,
    output logic [ges_pkg::IDX_W-1:0]            o_unknown_index,
    output logic signed [ges_pkg::DATA_W-1:0]    o_solution,
    output logic                                 o_singular,
    output logic                                 o_final_res
);

    localparam int DW = ges_pkg::DATA_W;
    localparam int AD = 1 << (2 * IW);
    localparam int BD = 1 << IW;
    localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    logic signed [DW-1:0] mem_a [0:AD-1];
    logic signed [DW-1:0] mem_b [0:BD-1];
    logic signed [DW-1:0] mem_x [0:BD-1];

    logic signed [DW-1:0] r_a_q, r_b_q, r_x_q;
    logic [1:0]           r_rsel;
    logic signed [DW-1:0] r_piv, r_f, r_t, r_acc;
    logic signed [63:0]   r_p;
    logic signed [DW-1:0] r_m;
    logic [ges_pkg::IDX_W-1:0] r_out_idx;
    logic signed [DW-1:0] r_out_sol;
    logic                 r_out_sing;
    logic                 r_out_fin;

    logic signed [DW-1:0] w_rdata;
    logic signed [DW-1:0] w_quot;
    logic                 w_div_done;
    logic [IW-1:0]        w_ld_row, w_ld_col;
    logic                 w_ld_row_ok, w_ld_col_ok;
    logic                 w_we_a, w_we_b, w_we_x;
    logic [2*IW-1:0]      w_a_waddr;
    logic [IW-1:0]        w_b_waddr;
    logic signed [DW-1:0] w_a_wdata, w_b_wdata, w_wdata;
    logic signed [63:0]   w_adj, w_sh;
    logic signed [DW:0]   w_dif_rd, w_dif_acc;
    logic signed [DW-1:0] w_sub_rd, w_sub_acc;

    // Load transaction decode; out-of-range indices write nothing.
    assign w_ld_row    = IW'(i_row);
    assign w_ld_col    = IW'(i_col);
    assign w_ld_row_ok = (32'(i_row) < MAX_N);
    assign w_ld_col_ok = (32'(i_col) < MAX_N);

    // Saturating subtractions.
    assign w_dif_rd  = {w_rdata[DW-1], w_rdata} - {r_m[DW-1], r_m};
    assign w_dif_acc = {r_acc[DW-1], r_acc} - {r_m[DW-1], r_m};
    assign w_sub_rd  = (w_dif_rd[DW] != w_dif_rd[DW-1]) ?
                       (w_dif_rd[DW] ? SMIN : SMAX) : w_dif_rd[DW-1:0];
    assign w_sub_acc = (w_dif_acc[DW] != w_dif_acc[DW-1]) ?
                       (w_dif_acc[DW] ? SMIN : SMAX) : w_dif_acc[DW-1:0];

    // Compute write data.
    always_comb begin
        case (i_cmd.wr_src)
            ges_pkg::SRC_DIV: w_wdata = w_quot;
            ges_pkg::SRC_SUB: w_wdata = w_sub_rd;
            ges_pkg::SRC_ACC: w_wdata = r_acc;
            default:          w_wdata = r_acc;
        endcase
    end

    // Write port selection between load transactions and solve steps.
    always_comb begin
        if (i_cmd.load_en) begin
            w_we_a    = w_ld_row_ok && w_ld_col_ok && !i_is_rhs;
            w_we_b    = w_ld_row_ok && i_is_rhs;
            w_we_x    = 1'b0;
            w_a_waddr = {w_ld_row, w_ld_col};
            w_b_waddr = w_ld_row;
            w_a_wdata = i_value;
            w_b_wdata = i_value;
        end else begin
            w_we_a    = (i_cmd.wr_mem == ges_pkg::MEM_A);
            w_we_b    = (i_cmd.wr_mem == ges_pkg::MEM_B);
            w_we_x    = (i_cmd.wr_mem == ges_pkg::MEM_X);
            w_a_waddr = {i_row_addr, i_col_addr};
            w_b_waddr = i_row_addr;
            w_a_wdata = w_wdata;
            w_b_wdata = w_wdata;
        end
    end

    // Coefficient memory.
    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            mem_a[w_a_waddr] <= w_a_wdata;
        end
        if (i_cmd.rd_mem == ges_pkg::MEM_A) begin
            r_a_q <= mem_a[{i_row_addr, i_col_addr}];
        end
    end

    // Right-hand side memory.
    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            mem_b[w_b_waddr] <= w_b_wdata;
        end
        if (i_cmd.rd_mem == ges_pkg::MEM_B) begin
            r_b_q <= mem_b[i_row_addr];
        end
    end

    // Solution memory.
    always_ff @(posedge i_clk) begin
        if (w_we_x) begin
            mem_x[i_row_addr] <= w_wdata;
        end
        if (i_cmd.rd_mem == ges_pkg::MEM_X) begin
            r_x_q <= mem_x[i_row_addr];
        end
    end

    // Read data selection is registered together with the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsel <= ges_pkg::MEM_NONE;
        end else begin
            r_rsel <= i_cmd.rd_mem;
        end
    end

    always_comb begin
        case (r_rsel)
            ges_pkg::MEM_A: w_rdata = r_a_q;
            ges_pkg::MEM_B: w_rdata = r_b_q;
            ges_pkg::MEM_X: w_rdata = r_x_q;
            default:        w_rdata = r_a_q;
        endcase
    end

    // Operand registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_p) begin
            r_piv <= w_rdata;
        end
        if (i_cmd.ld_f) begin
            r_f <= w_rdata;
        end
        if (i_cmd.ld_t) begin
            r_t <= w_rdata;
        end
        if (i_cmd.ld_acc) begin
            r_acc <= w_rdata;
        end else if (i_cmd.acc_sub) begin
            r_acc <= w_sub_acc;
        end
    end

    // Two-stage multiplier: product, then scaling toward zero and saturation.
    assign w_adj = r_p + (r_p[63] ? RND : 64'sd0);
    assign w_sh  = w_adj >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(r_t) * 64'(r_f);
        if (w_sh > 64'(SMAX)) begin
            r_m <= SMAX;
        end else if (w_sh < 64'(SMIN)) begin
            r_m <= SMIN;
        end else begin
            r_m <= w_sh[DW-1:0];
        end
    end

    // Divider for pivot row normalization.
    ges_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_rdata),
        .i_den   (r_piv),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_idx  <= ges_pkg::IDX_W'(i_row_addr);
            r_out_sol  <= i_cmd.out_sing ? '0 : w_rdata;
            r_out_sing <= i_cmd.out_sing;
            r_out_fin  <= i_cmd.out_final;
        end
    end

    assign o_sts.rd_zero  = (w_rdata == '0);
    assign o_sts.div_done = w_div_done;

    assign o_unknown_index = r_out_idx;
    assign o_solution      = r_out_sol;
    assign o_singular      = r_out_sing;
    assign o_final_res     = r_out_fin;

endmodule

// File: rtl/ges_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian elimination controller
// Sequences loads, forward elimination, back substitution and result
// delivery, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module ges_ctrl #(
    parameter int MAX_N = 8,
    parameter int IW    = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ges_pkg::SIZE_W-1:0]   i_size,
    input  logic                         i_valid,
    input  logic                         i_last,
    output logic                         o_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ges_pkg::t_cmd                o_cmd,
    output logic [IW-1:0]                o_row_addr,
    output logic [IW-1:0]                o_col_addr,
    input  ges_pkg::t_sts                i_sts
);

    localparam int CW    = $clog2(MAX_N + 1);
    localparam int LIMIT = (MAX_N < ges_pkg::RES_LIMIT) ? MAX_N : ges_pkg::RES_LIMIT;

    localparam logic [5:0] S_IDLE      = 6'd0;
    localparam logic [5:0] S_E_PIV_RD  = 6'd1;
    localparam logic [5:0] S_E_PIV_CHK = 6'd2;
    localparam logic [5:0] S_E_DB_RD   = 6'd3;
    localparam logic [5:0] S_E_DB_GO   = 6'd4;
    localparam logic [5:0] S_E_DB_WAIT = 6'd5;
    localparam logic [5:0] S_E_DA_RD   = 6'd6;
    localparam logic [5:0] S_E_DA_GO   = 6'd7;
    localparam logic [5:0] S_E_DA_WAIT = 6'd8;
    localparam logic [5:0] S_E_F_RD    = 6'd9;
    localparam logic [5:0] S_E_F_LD    = 6'd10;
    localparam logic [5:0] S_E_SB_RD   = 6'd11;
    localparam logic [5:0] S_E_SB_T    = 6'd12;
    localparam logic [5:0] S_E_SB_M1   = 6'd13;
    localparam logic [5:0] S_E_SB_M2   = 6'd14;
    localparam logic [5:0] S_E_SB_W    = 6'd15;
    localparam logic [5:0] S_E_SA_RD   = 6'd16;
    localparam logic [5:0] S_E_SA_T    = 6'd17;
    localparam logic [5:0] S_E_SA_M1   = 6'd18;
    localparam logic [5:0] S_E_SA_M2   = 6'd19;
    localparam logic [5:0] S_E_SA_W    = 6'd20;
    localparam logic [5:0] S_B_RD      = 6'd21;
    localparam logic [5:0] S_B_ACC     = 6'd22;
    localparam logic [5:0] S_B_A_RD    = 6'd23;
    localparam logic [5:0] S_B_T       = 6'd24;
    localparam logic [5:0] S_B_F       = 6'd25;
    localparam logic [5:0] S_B_M1      = 6'd26;
    localparam logic [5:0] S_B_M2      = 6'd27;
    localparam logic [5:0] S_B_SUB     = 6'd28;
    localparam logic [5:0] S_B_WR      = 6'd29;
    localparam logic [5:0] S_O_RD      = 6'd30;
    localparam logic [5:0] S_O_LD      = 6'd31;
    localparam logic [5:0] S_O_WAIT    = 6'd32;

    // Address source codes.
    localparam logic [1:0] A_I = 2'd0;
    localparam logic [1:0] A_J = 2'd1;
    localparam logic [1:0] A_K = 2'd2;

    logic [5:0]    r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic          r_sing, n_sing;
    logic [CW-1:0] w_n;
    logic [CW-1:0] w_i1, w_j1, w_k1;
    logic [1:0]    w_rsrc, w_csrc;
    logic          w_accept;

    // Effective system size: zero acts as one, large values clamp.
    always_comb begin
        if (i_size == '0) begin
            w_n = CW'(1);
        end else if (32'(i_size) > LIMIT) begin
            w_n = CW'(LIMIT);
        end else begin
            w_n = CW'(i_size);
        end
    end

    assign w_i1     = r_i + CW'(1);
    assign w_j1     = r_j + CW'(1);
    assign w_k1     = r_k + CW'(1);
    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_O_WAIT);

    // State and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_sing  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_sing  <= n_sing;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_sing  = r_sing;
        o_cmd   = '0;
        o_cmd.rd_mem    = ges_pkg::MEM_NONE;
        o_cmd.wr_mem    = ges_pkg::MEM_NONE;
        o_cmd.wr_src    = ges_pkg::SRC_DIV;
        o_cmd.out_sing  = r_sing;
        o_cmd.out_final = (w_i1 == w_n);
        w_rsrc  = A_I;
        w_csrc  = A_I;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_en = w_accept;
                if (w_accept && i_last) begin
                    n_sing  = 1'b0;
                    n_i     = '0;
                    n_state = S_E_PIV_RD;
                end
            end
            // Pivot fetch and zero check.
            S_E_PIV_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_A;
                n_state      = S_E_PIV_CHK;
            end
            S_E_PIV_CHK: begin
                o_cmd.ld_p = 1'b1;
                if (i_sts.rd_zero) begin
                    n_sing  = 1'b1;
                    n_i     = '0;
                    n_state = S_O_RD;
                end else begin
                    n_state = S_E_DB_RD;
                end
            end
            // Normalize the right-hand side of the pivot row.
            S_E_DB_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_B;
                n_state      = S_E_DB_GO;
            end
            S_E_DB_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_E_DB_WAIT;
            end
            S_E_DB_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.wr_mem = ges_pkg::MEM_B;
                    o_cmd.wr_src = ges_pkg::SRC_DIV;
                    n_j          = r_i;
                    n_state      = S_E_DA_RD;
                end
            end
            // Normalize the pivot row coefficients.
            S_E_DA_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_A;
                w_csrc       = A_J;
                n_state      = S_E_DA_GO;
            end
            S_E_DA_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_E_DA_WAIT;
            end
            S_E_DA_WAIT: begin
                w_csrc = A_J;
                if (i_sts.div_done) begin
                    o_cmd.wr_mem = ges_pkg::MEM_A;
                    o_cmd.wr_src = ges_pkg::SRC_DIV;
                    if (w_j1 == w_n) begin
                        n_k = w_i1;
                        if (w_i1 == w_n) begin
                            n_i     = w_n - CW'(1);
                            n_state = S_B_RD;
                        end else begin
                            n_state = S_E_F_RD;
                        end
                    end else begin
                        n_j     = w_j1;
                        n_state = S_E_DA_RD;
                    end
                end
            end
            // Fetch the elimination factor of row k.
            S_E_F_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_A;
                w_rsrc       = A_K;
                n_state      = S_E_F_LD;
            end
            S_E_F_LD: begin
                o_cmd.ld_f = 1'b1;
                n_state    = S_E_SB_RD;
            end
            // Update the right-hand side of row k.
            S_E_SB_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_B;
                n_state      = S_E_SB_T;
            end
            S_E_SB_T: begin
                o_cmd.ld_t = 1'b1;
                n_state    = S_E_SB_M1;
            end
            S_E_SB_M1: begin
                n_state = S_E_SB_M2;
            end
            S_E_SB_M2: begin
                o_cmd.rd_mem = ges_pkg::MEM_B;
                w_rsrc       = A_K;
                n_state      = S_E_SB_W;
            end
            S_E_SB_W: begin
                o_cmd.wr_mem = ges_pkg::MEM_B;
                o_cmd.wr_src = ges_pkg::SRC_SUB;
                w_rsrc       = A_K;
                n_j          = r_i;
                n_state      = S_E_SA_RD;
            end
            // Update the coefficients of row k.
            S_E_SA_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_A;
                w_csrc       = A_J;
                n_state      = S_E_SA_T;
            end
            S_E_SA_T: begin
                o_cmd.ld_t = 1'b1;
                n_state    = S_E_SA_M1;
            end
            S_E_SA_M1: begin
                n_state = S_E_SA_M2;
            end
            S_E_SA_M2: begin
                o_cmd.rd_mem = ges_pkg::MEM_A;
                w_rsrc       = A_K;
                w_csrc       = A_J;
                n_state      = S_E_SA_W;
            end
            S_E_SA_W: begin
                o_cmd.wr_mem = ges_pkg::MEM_A;
                o_cmd.wr_src = ges_pkg::SRC_SUB;
                w_rsrc       = A_K;
                w_csrc       = A_J;
                if (w_j1 == w_n) begin
                    if (w_k1 == w_n) begin
                        n_i     = w_i1;
                        n_state = S_E_PIV_RD;
                    end else begin
                        n_k     = w_k1;
                        n_state = S_E_F_RD;
                    end
                end else begin
                    n_j     = w_j1;
                    n_state = S_E_SA_RD;
                end
            end
            // Back substitution, bottom row first.
            S_B_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_B;
                n_state      = S_B_ACC;
            end
            S_B_ACC: begin
                o_cmd.ld_acc = 1'b1;
                n_j          = w_i1;
                n_state      = (w_i1 == w_n) ? S_B_WR : S_B_A_RD;
            end
            S_B_A_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_A;
                w_csrc       = A_J;
                n_state      = S_B_T;
            end
            S_B_T: begin
                o_cmd.ld_t   = 1'b1;
                o_cmd.rd_mem = ges_pkg::MEM_X;
                w_rsrc       = A_J;
                n_state      = S_B_F;
            end
            S_B_F: begin
                o_cmd.ld_f = 1'b1;
                n_state    = S_B_M1;
            end
            S_B_M1: begin
                n_state = S_B_M2;
            end
            S_B_M2: begin
                n_state = S_B_SUB;
            end
            S_B_SUB: begin
                o_cmd.acc_sub = 1'b1;
                n_j           = w_j1;
                n_state       = (w_j1 == w_n) ? S_B_WR : S_B_A_RD;
            end
            S_B_WR: begin
                o_cmd.wr_mem = ges_pkg::MEM_X;
                o_cmd.wr_src = ges_pkg::SRC_ACC;
                if (r_i == '0) begin
                    n_state = S_O_RD;
                end else begin
                    n_i     = r_i - CW'(1);
                    n_state = S_B_RD;
                end
            end
            // Result delivery, one unknown per transaction.
            S_O_RD: begin
                o_cmd.rd_mem = ges_pkg::MEM_X;
                n_state      = S_O_LD;
            end
            S_O_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = S_O_WAIT;
            end
            S_O_WAIT: begin
                if (i_ready) begin
                    if (w_i1 == w_n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = w_i1;
                        n_state = S_O_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Address selection from the loop counters.
    always_comb begin
        case (w_rsrc)
            A_I:     o_row_addr = r_i[IW-1:0];
            A_J:     o_row_addr = r_j[IW-1:0];
            A_K:     o_row_addr = r_k[IW-1:0];
            default: o_row_addr = r_i[IW-1:0];
        endcase
        case (w_csrc)
            A_I:     o_col_addr = r_i[IW-1:0];
            A_J:     o_col_addr = r_j[IW-1:0];
            default: o_col_addr = r_i[IW-1:0];
        endcase
    end

endmodule

// File: rtl/gaussian_elimination_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian elimination solver
// Dense linear system solver in signed fixed point, no pivoting.
// ----------------------------------------------------------------------------
// Usage: each input transaction writes one coefficient A[row][col] or, with
// i_is_rhs set, one right-hand side entry b[row]. The transaction with
// i_last set writes its entry and starts a solve over the first
// system_size equations. Input ready is low from then until the last
// result transaction completes.
// The solve runs one operation at a time through a shared divider, one
// multiplier and one memory read port. Results then leave one per unknown
// in index order; a stalled receiver simply holds the result register.
// A zero pivot ends elimination early and all results carry zero with the
// singular flag set. The user must write system_size through the APB port
// only while the block is idle; the block itself does not enforce this.
// Reset sets system_size to 8 and leaves the stores undefined.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver #(
    parameter int MAX_N     = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [1:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ges_pkg::IDX_W-1:0]         i_row,
    input  logic [ges_pkg::IDX_W-1:0]         i_col,
    input  logic                              i_is_rhs,
    input  logic signed [ges_pkg::DATA_W-1:0] i_value,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ges_pkg::IDX_W-1:0]         o_unknown_index,
    output logic signed [ges_pkg::DATA_W-1:0] o_solution,
    output logic                              o_singular,
    output logic                              o_final_res
);

    localparam int IW = $clog2(MAX_N);

    logic [ges_pkg::SIZE_W-1:0] r_size;
    ges_pkg::t_cmd              w_cmd;
    ges_pkg::t_sts              w_sts;
    logic [IW-1:0]              w_row_addr;
    logic [IW-1:0]              w_col_addr;

    // Configuration register; the single register decodes at every address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= ges_pkg::SIZE_W'(8);
        end else if (psel && penable && pwrite) begin
            r_size <= pwdata[ges_pkg::SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {{(32 - ges_pkg::SIZE_W){1'b0}}, r_size};

    ges_ctrl #(
        .MAX_N (MAX_N),
        .IW    (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_size     (r_size),
        .i_valid    (i_valid),
        .i_last     (i_last),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_cmd      (w_cmd),
        .o_row_addr (w_row_addr),
        .o_col_addr (w_col_addr),
        .i_sts      (w_sts)
    );

    ges_dp #(
        .MAX_N     (MAX_N),
        .FRAC_BITS (FRAC_BITS),
        .IW        (IW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_row_addr      (w_row_addr),
        .i_col_addr      (w_col_addr),
        .o_sts           (w_sts),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_is_rhs        (i_is_rhs),
        .i_value         (i_value),
        .o_unknown_index (o_unknown_index),
        .o_solution      (o_solution),
        .o_singular      (o_singular),
        .o_final_res     (o_final_res)
    );

endmodule
